// File: rtl/core/arp_pkg.sv
// Shared types and constants for the ARP responder with address cache.
package arp_pkg;

  localparam int CACHE_ENTRIES_DEF = 16;

  // Item operation codes
  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_HIT   = 2'd2;
  localparam logic [1:0] KIND_MISS  = 2'd3;

  // ARP header constants
  localparam logic [15:0] HTYPE_ETH  = 16'h0001;
  localparam logic [15:0] PTYPE_IP4  = 16'h0800;
  localparam logic [15:0] OPER_REQ   = 16'd1;
  localparam logic [15:0] MIN_LEN    = 16'd28;
  localparam logic [1:0]  TX_OPER_REQ = 2'd1;
  localparam logic [1:0]  TX_OPER_REP = 2'd2;
  localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes
  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  CFG_LOCAL_IP  = 2'd0;
  localparam logic [1:0]  CFG_LOCAL_MAC = 2'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] payload_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] arp_oper;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [47:0] tx_dst_mac;
    logic [1:0]  tx_oper;
    logic [47:0] tx_sender_mac;
    logic [31:0] tx_sender_ip;
    logic [47:0] tx_target_mac;
    logic [31:0] tx_target_ip;
    logic [47:0] found_mac;
  } out_t;

  // Search token walking down the cell row
  typedef struct packed {
    logic        valid;
    logic        hit;   // a match was seen upstream
    logic        free;  // a free slot was seen upstream
    logic [47:0] mac;   // MAC of the first match
  } token_t;

  // Cache write command broadcast to every cell
  typedef struct packed {
    logic        we;
    logic        use_hit;
    logic        use_free;
    logic [31:0] ip;
    logic [47:0] mac;
  } wr_t;

endpackage

// File: rtl/core/arp_cell.sv
// One cache slot: holds an entry, checks the passing token, takes writes.
module arp_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      key,
  input  arp_pkg::token_t  tok_in,
  output arp_pkg::token_t  tok_out,
  input  arp_pkg::wr_t     wr
);

  logic        entry_valid;
  logic [31:0] entry_ip;
  logic [47:0] entry_mac;
  logic        sel_hit;
  logic        sel_free;
  logic        match;
  logic        write_sel;
  arp_pkg::token_t tok_next;

  assign match = entry_valid && (entry_ip == key);

  // first match / first free seen by this token lands here
  always_comb begin
    tok_next       = tok_in;
    tok_next.hit   = tok_in.hit || match;
    tok_next.free  = tok_in.free || !entry_valid;
    if (!tok_in.hit && match) begin
      tok_next.mac = entry_mac;
    end
  end

  // slot 0 takes the write when nothing matched and nothing is free
  assign write_sel = wr.we && (wr.use_hit  ? sel_hit  :
                               wr.use_free ? sel_free : FIRST);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      tok_out     <= '0;
    end else begin
      tok_out <= tok_in.valid ? tok_next : '0;
      if (write_sel) begin
        entry_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      sel_hit  <= !tok_in.hit && match;
      sel_free <= !tok_in.free && !entry_valid;
    end
    if (write_sel) begin
      entry_ip  <= wr.ip;
      entry_mac <= wr.mac;
    end
  end

endmodule

// File: rtl/core/arp_responder_with_cache.sv
// Top level: ARP responder with a learned IP/MAC cache built as a row of cells.
// Result path: send-request, unused-op and dropped-frame items give their result
//   in the cycle after acceptance; for received frames and lookups the token is
//   registered at injection, then in each cache cell, then the result word.
// Flow: busy holds off new items for the whole of a search; other items do not.
// Reset: synchronous, clears all entry valid bits at once; no clearing pass.
// Each new result is flagged by done, high for one cycle; the receiver cannot stall.
module arp_responder_with_cache #(
  parameter int CACHE_ENTRIES = arp_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  arp_pkg::in_t                  item,
  // result channel
  output logic                          done,
  output arp_pkg::out_t                 result,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]                   cfg_data
);

  typedef enum logic {
    IDLE,
    SEARCH
  } state_t;

  state_t          state;
  arp_pkg::in_t    cur;        // item under search
  arp_pkg::token_t tok0;       // token injected into cell 0
  arp_pkg::token_t tok0_next;
  logic            done_next;
  logic [31:0]     own_ip;
  logic [47:0]     own_mac;

  arp_pkg::token_t tok [CACHE_ENTRIES+1];
  arp_pkg::token_t tok_last;
  logic [CACHE_ENTRIES-1:0] tok_vld;
  arp_pkg::wr_t    wr;

  logic          accept;
  logic          rx_ok;
  logic          needs_search;
  logic          search_key_rx;
  logic [31:0]   key;
  arp_pkg::out_t req_frame;
  arp_pkg::out_t end_res;

  assign busy      = (state == SEARCH);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Frame sanity: length, hardware type and protocol type
  assign rx_ok = (item.payload_len >= arp_pkg::MIN_LEN) &&
                 (item.hw_type == arp_pkg::HTYPE_ETH) &&
                 (item.proto_type == arp_pkg::PTYPE_IP4);

  assign needs_search = ((item.op == arp_pkg::OP_RX) && rx_ok) ||
                        (item.op == arp_pkg::OP_LOOKUP);

  // Received frames search on the sender IP (learning), lookups on query_ip
  assign search_key_rx = (cur.op == arp_pkg::OP_RX);
  assign key           = search_key_rx ? cur.sender_ip : cur.query_ip;

  // ---------------------------------------------------------------------------
  // Cell row: token enters at cell 0 and moves one cell per cycle
  // ---------------------------------------------------------------------------
  assign tok[0]   = tok0;
  assign tok_last = tok[CACHE_ENTRIES];

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    arp_cell #(
      .FIRST (i == 0)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .key     (key),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .wr      (wr)
    );
    assign tok_vld[i] = tok[i+1].valid;
  end

  // Learn the sender pair when the token leaves the last cell.
  // Existing entry wins, else first free slot, else slot 0.
  always_comb begin
    wr.we       = (state == SEARCH) && tok_last.valid && search_key_rx;
    wr.use_hit  = tok_last.hit;
    wr.use_free = tok_last.free;
    wr.ip       = cur.sender_ip;
    wr.mac      = cur.sender_mac;
  end

  // Broadcast who-has frame for a send-request item
  always_comb begin
    req_frame               = '0;
    req_frame.result_kind   = arp_pkg::KIND_FRAME;
    req_frame.tx_dst_mac    = arp_pkg::BCAST_MAC;
    req_frame.tx_oper       = arp_pkg::TX_OPER_REQ;
    req_frame.tx_sender_mac = own_mac;
    req_frame.tx_sender_ip  = own_ip;
    req_frame.tx_target_ip  = item.query_ip;
  end

  // Result at the end of a search: lookup hit/miss, reply to a request for own IP, else none
  always_comb begin
    end_res = '0;
    if (cur.op == arp_pkg::OP_LOOKUP) begin
      if (tok_last.hit) begin
        end_res.result_kind = arp_pkg::KIND_HIT;
        end_res.found_mac   = tok_last.mac;
      end else begin
        end_res.result_kind = arp_pkg::KIND_MISS;
      end
    end else if ((cur.arp_oper == arp_pkg::OPER_REQ) && (cur.target_ip == own_ip)) begin
      end_res.result_kind   = arp_pkg::KIND_FRAME;
      end_res.tx_dst_mac    = cur.sender_mac;
      end_res.tx_oper       = arp_pkg::TX_OPER_REP;
      end_res.tx_sender_mac = own_mac;
      end_res.tx_sender_ip  = own_ip;
      end_res.tx_target_mac = cur.sender_mac;
      end_res.tx_target_ip  = cur.sender_ip;
    end
  end

  // Token launch and result strobe for the coming cycle
  always_comb begin
    tok0_next       = '0;
    tok0_next.valid = (state == IDLE) && accept && needs_search;
  end

  assign done_next = ((state == IDLE) && accept && !needs_search) ||
                     ((state == SEARCH) && tok_last.valid);

  // ---------------------------------------------------------------------------
  // Control: state, token injection and the registered result word
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      tok0  <= '0;
    end else begin
      done <= done_next;
      tok0 <= tok0_next;
      case (state)
        IDLE: begin
          if (accept) begin
            if (needs_search) begin
              state <= SEARCH;
            end else begin
              // send request, dropped frame or unused op: answer at once
              result <= (item.op == arp_pkg::OP_REQUEST) ? req_frame : '0;
            end
          end
        end
        SEARCH: begin
          if (tok_last.valid) begin
            result <= end_res;
            state  <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // item fields stay put for the whole search
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
  end

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arp_pkg::CFG_LOCAL_IP:  own_ip  <= cfg_data[31:0];
        arp_pkg::CFG_LOCAL_MAC: own_mac <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({tok0.valid, tok_vld}))
    else $error("more than one search token in the cell row");

  a_token_in_search: assert property (@(posedge clk) disable iff (rst)
    tok_last.valid |-> (state == SEARCH))
    else $error("token left the row outside a search");

  a_write_ends: assert property (@(posedge clk) disable iff (rst)
    wr.we |=> (!busy && done))
    else $error("cache write not followed by result and idle");

  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && needs_search) |=> (busy && tok0.valid && !done))
    else $error("search item did not start a search");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !needs_search) |=> (done && !busy))
    else $error("immediate item gave no result next cycle");

endmodule
